// ===== rtl/core/dja_pkg.sv =====
// Package for the dijet asymmetry selector: register indexes, class codes,
// back-end states and the event record passed from the front to the back. No dependencies.
`default_nettype none
package dja_pkg;
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PT_FLOOR  = 3'd0,
        REG_LEAD_MIN  = 3'd1,
        REG_SUB_MIN   = 3'd2,
        REG_DPHI_MIN  = 3'd3,
        REG_CENT_EDGE = 3'd4,
        REG_MID_EDGE  = 3'd5,
        REG_PERI_EDGE = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_CENT = 2'd1,
        CLS_MID  = 2'd2,
        CLS_PERI = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_OUT  = 2'd2
    } t_bk_state;

    typedef struct packed {
        logic [1:0] truth_class;
        logic [1:0] reco_class;
    } t_ev_cls;
endpackage
`default_nettype wire

// ===== rtl/core/dijet_asymmetry_selector.sv =====
// Top level of the dijet asymmetry selector: config registers, front,
// queue and back. Uses dja_pkg, dja_front, dja_queue, dja_back.
//
//  channel | signals                          | direction
//  jet     | i_valid / o_ready + jet fields   | in
//  cfg     | i_cfg_valid / o_cfg_ready        | in
//  result  | o_valid / i_ready + result fields| out
//
// One jet a cycle at the front. Each event then runs through four divisions
// in the back on the shared one-bit-a-cycle divider, and the back takes no
// new event until its result has been taken; a two-entry queue
// lets the front run on meanwhile. Reset is synchronous and active low.
// The front stalls a last jet only when the queue is full.
`default_nettype none
module dijet_asymmetry_selector #(
    parameter int PT_WIDTH        = 16,
    parameter int PHI_WIDTH       = 16,
    parameter int RATIO_FRAC_BITS = 14
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire        [PT_WIDTH-1:0]   i_truth_pt,
    input  wire signed [PHI_WIDTH-1:0]  i_truth_phi,
    input  wire        [PT_WIDTH-1:0]   i_reco_pt,
    input  wire signed [PHI_WIDTH-1:0]  i_reco_phi,
    input  wire        [6:0]            i_truth_centrality,
    input  wire        [6:0]            i_reco_centrality,
    input  wire                         i_last_jet,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire        [dja_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire        [15:0]           i_cfg_data,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic signed [15:0]          o_aj_truth,
    output logic signed [15:0]          o_aj_reco,
    output logic       [15:0]           o_xj_truth,
    output logic       [15:0]           o_xj_reco,
    output logic                        o_pair_selected,
    output logic       [1:0]            o_truth_class,
    output logic       [1:0]            o_reco_class,
    output logic                        o_reco_negative
);
    import dja_pkg::*;

    localparam int EW = 4*PT_WIDTH + 4*PHI_WIDTH;

    logic [15:0] r_floor, r_lmin, r_smin;
    logic [14:0] r_dphi;
    logic [6:0] r_ce, r_me, r_pe;
    logic ev_valid, ev_ready, q_valid, q_ready;
    logic [EW-1:0] ev_data;
    t_ev_cls ev_cls;
    logic [EW+3:0] q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= 16'd80; r_lmin <= 16'd160; r_smin <= 16'd80; r_dphi <= 15'd6431;
            r_ce <= 7'd20; r_me <= 7'd50; r_pe <= 7'd100;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PT_FLOOR:  r_floor <= i_cfg_data;
                REG_LEAD_MIN:  r_lmin <= i_cfg_data;
                REG_SUB_MIN:   r_smin <= i_cfg_data;
                REG_DPHI_MIN:  r_dphi <= i_cfg_data[14:0];
                REG_CENT_EDGE: r_ce <= i_cfg_data[6:0];
                REG_MID_EDGE:  r_me <= i_cfg_data[6:0];
                REG_PERI_EDGE: r_pe <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    dja_front #(.PT_W(PT_WIDTH), .PHI_W(PHI_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_truth_pt, .i_truth_phi, .i_reco_pt, .i_reco_phi,
        .i_truth_centrality, .i_reco_centrality, .i_last_jet,
        .i_pt_floor(r_floor), .i_cent_edge(r_ce), .i_mid_edge(r_me), .i_peri_edge(r_pe),
        .o_ev_valid(ev_valid), .i_ev_ready(ev_ready), .o_ev_data(ev_data), .o_ev_cls(ev_cls)
    );

    dja_queue #(.W(EW+4)) u_queue (
        .i_clk, .i_rst_n, .i_valid(ev_valid), .o_ready(ev_ready),
        .i_data({ev_data, ev_cls}), .o_valid(q_valid), .i_ready(q_ready), .o_data(q_data)
    );

    dja_back #(.PT_W(PT_WIDTH), .PHI_W(PHI_WIDTH), .FRAC(RATIO_FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_ready(q_ready), .i_data(q_data),
        .i_lead_min(r_lmin), .i_sub_min(r_smin), .i_dphi_min(r_dphi),
        .o_valid, .i_ready, .o_aj_truth, .o_aj_reco, .o_xj_truth, .o_xj_reco,
        .o_pair_selected, .o_truth_class, .o_reco_class, .o_reco_negative
    );
endmodule
`default_nettype wire

// ===== rtl/core/dja_front.sv =====
// Front end: skips jets under the floor, keeps the top two by truth pt and
// hands a finished event to the queue on the last jet. Uses dja_pkg.
`default_nettype none
module dja_front #(
    parameter int PT_W  = 16,
    parameter int PHI_W = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire        [PT_W-1:0]   i_truth_pt,
    input  wire signed [PHI_W-1:0]  i_truth_phi,
    input  wire        [PT_W-1:0]   i_reco_pt,
    input  wire signed [PHI_W-1:0]  i_reco_phi,
    input  wire        [6:0]        i_truth_centrality,
    input  wire        [6:0]        i_reco_centrality,
    input  wire                     i_last_jet,
    input  wire        [15:0]       i_pt_floor,
    input  wire        [6:0]        i_cent_edge,
    input  wire        [6:0]        i_mid_edge,
    input  wire        [6:0]        i_peri_edge,
    output logic                    o_ev_valid,
    input  wire                     i_ev_ready,
    output logic       [4*PT_W+4*PHI_W-1:0] o_ev_data,
    output dja_pkg::t_ev_cls        o_ev_cls
);
    import dja_pkg::*;

    logic [PT_W-1:0] r_lt_pt, r_st_pt, r_lr_pt, r_sr_pt;
    logic signed [PHI_W-1:0] r_lt_ph, r_st_ph, r_lr_ph, r_sr_ph;
    logic [PT_W-1:0] n_lt_pt, n_st_pt, n_lr_pt, n_sr_pt;
    logic signed [PHI_W-1:0] n_lt_ph, n_st_ph, n_lr_ph, n_sr_ph;
    logic keep, take;

    function automatic logic [1:0] class_of(input logic [6:0] c, input logic [6:0] ce,
                                            input logic [6:0] me, input logic [6:0] pe);
        if (c != 7'd0 && c <= ce) return CLS_CENT;
        if (c > ce && c <= me) return CLS_MID;
        if (c > me && c <= pe) return CLS_PERI;
        return CLS_NONE;
    endfunction

    // stall only when an event must go out and the queue is full
    assign o_ready = !i_last_jet || i_ev_ready;
    assign take = i_valid && o_ready;
    assign keep = {{(32-PT_W){1'b0}}, i_truth_pt} >= {16'd0, i_pt_floor};

    always_comb begin
        n_lt_pt = r_lt_pt; n_st_pt = r_st_pt; n_lr_pt = r_lr_pt; n_sr_pt = r_sr_pt;
        n_lt_ph = r_lt_ph; n_st_ph = r_st_ph; n_lr_ph = r_lr_ph; n_sr_ph = r_sr_ph;
        if (keep) begin
            if (i_truth_pt > r_lt_pt) begin
                n_st_pt = r_lt_pt; n_st_ph = r_lt_ph;
                n_sr_pt = r_lr_pt; n_sr_ph = r_lr_ph;
                n_lt_pt = i_truth_pt; n_lt_ph = i_truth_phi;
                n_lr_pt = i_reco_pt;  n_lr_ph = i_reco_phi;
            end else if (i_truth_pt > r_st_pt) begin
                n_st_pt = i_truth_pt; n_st_ph = i_truth_phi;
                n_sr_pt = i_reco_pt;  n_sr_ph = i_reco_phi;
            end
        end
    end

    assign o_ev_valid = i_valid && i_last_jet;
    assign o_ev_data = {n_lt_pt, n_st_pt, n_lr_pt, n_sr_pt,
                        n_lt_ph, n_st_ph, n_lr_ph, n_sr_ph};
    assign o_ev_cls.truth_class = class_of(i_truth_centrality, i_cent_edge, i_mid_edge,
                                           i_peri_edge);
    assign o_ev_cls.reco_class = class_of(i_reco_centrality, i_cent_edge, i_mid_edge,
                                          i_peri_edge);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (take && i_last_jet)) begin
            r_lt_pt <= '0; r_st_pt <= '0; r_lr_pt <= '0; r_sr_pt <= '0;
            r_lt_ph <= '0; r_st_ph <= '0; r_lr_ph <= '0; r_sr_ph <= '0;
        end else if (take) begin
            r_lt_pt <= n_lt_pt; r_st_pt <= n_st_pt; r_lr_pt <= n_lr_pt; r_sr_pt <= n_sr_pt;
            r_lt_ph <= n_lt_ph; r_st_ph <= n_st_ph; r_lr_ph <= n_lr_ph; r_sr_ph <= n_sr_ph;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/dja_queue.sv =====
// Two-entry queue of event records between front and back. No dependencies.
`default_nettype none
module dja_queue #(
    parameter int W = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_ready,
    input  wire  [W-1:0] i_data,
    output logic         o_valid,
    input  wire          i_ready,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/dja_back.sv =====
// Back end: cuts, then four ratios through one shared restoring divider,
// one quotient bit a cycle. Uses dja_pkg.
`default_nettype none
module dja_back #(
    parameter int PT_W  = 16,
    parameter int PHI_W = 16,
    parameter int FRAC  = 14
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [4*PT_W+4*PHI_W+3:0] i_data,
    input  wire  [15:0]         i_lead_min,
    input  wire  [15:0]         i_sub_min,
    input  wire  [14:0]         i_dphi_min,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic signed [15:0]  o_aj_truth,
    output logic signed [15:0]  o_aj_reco,
    output logic [15:0]         o_xj_truth,
    output logic [15:0]         o_xj_reco,
    output logic                o_pair_selected,
    output logic [1:0]          o_truth_class,
    output logic [1:0]          o_reco_class,
    output logic                o_reco_negative
);
    import dja_pkg::*;

    localparam int DW = PT_W + 1;          // denominator width (sum)
    localparam int NW = DW + FRAC;         // dividend width
    localparam int CW = $clog2(NW + 1);

    t_bk_state r_st, n_st;
    logic [PT_W-1:0] lt, st_, lr, sr;
    logic signed [PHI_W-1:0] ltp, stp, lrp, srp;
    t_ev_cls cls;
    logic [PT_W-1:0] r_lt, r_st_pt, r_lr, r_sr;
    logic r_sel;
    t_ev_cls r_cls;
    logic [1:0] r_op;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num, r_q;
    logic [DW-1:0] r_den, r_rem;
    logic [DW:0] trial;
    logic [DW-1:0] num_mag, den;
    logic neg;
    logic [15:0] r_aj_t, r_aj_r, r_xj_t, r_xj_r;
    logic [PHI_W:0] dt, dr;
    logic sel;
    logic r_out_ok;

    assign {lt, st_, lr, sr, ltp, stp, lrp, srp, cls} = i_data;

    function automatic logic [PHI_W:0] adiff(input logic signed [PHI_W-1:0] a,
                                             input logic signed [PHI_W-1:0] b);
        logic signed [PHI_W:0] d;
        d = {a[PHI_W-1], a} - {b[PHI_W-1], b};
        return d[PHI_W] ? -d : d;
    endfunction

    assign dt = adiff(ltp, stp);
    assign dr = adiff(lrp, srp);
    assign sel = {{(33-PT_W){1'b0}}, lt} > {17'd0, i_lead_min}
              && {{(33-PT_W){1'b0}}, st_} > {17'd0, i_sub_min}
              && {{(32-PHI_W){1'b0}}, dt} > {18'd0, i_dphi_min}
              && {{(33-PT_W){1'b0}}, lr} > {17'd0, i_lead_min}
              && {{(33-PT_W){1'b0}}, sr} > {17'd0, i_sub_min}
              && {{(32-PHI_W){1'b0}}, dr} > {18'd0, i_dphi_min};

    // operand select: 0 aj truth, 1 aj reco, 2 xj truth, 3 xj reco
    always_comb begin
        num_mag = '0; den = '0; neg = 1'b0;
        case (r_op)
            2'd0: begin
                neg = r_st_pt > r_lt;
                num_mag = neg ? {1'b0, r_st_pt - r_lt} : {1'b0, r_lt - r_st_pt};
                den = {1'b0, r_lt} + {1'b0, r_st_pt};
            end
            2'd1: begin
                neg = r_sr > r_lr;
                num_mag = neg ? {1'b0, r_sr - r_lr} : {1'b0, r_lr - r_sr};
                den = {1'b0, r_lr} + {1'b0, r_sr};
            end
            2'd2: begin num_mag = {1'b0, r_st_pt}; den = {1'b0, r_lt}; end
            default: begin num_mag = {1'b0, r_sr}; den = {1'b0, r_lr}; end
        endcase
    end

    assign trial = {r_rem, r_num[NW-1]} - {1'b0, r_den};

    assign o_ready = r_st == BK_IDLE;
    assign o_valid = r_st == BK_OUT && r_out_ok;

    always_comb begin
        n_st = r_st;
        case (r_st)
            BK_IDLE: if (i_valid) n_st = BK_DIV;
            BK_DIV:  if (r_cnt == CW'(NW) && r_op == 2'd3) n_st = BK_OUT;
            BK_OUT:  if (i_ready && r_out_ok) n_st = BK_IDLE;
            default: n_st = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= BK_IDLE;
        else r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= 2'd0; r_cnt <= '0;
        end else if (r_st == BK_IDLE && i_valid) begin
            r_lt <= lt; r_st_pt <= st_; r_lr <= lr; r_sr <= sr;
            r_sel <= sel; r_cls <= cls;
            r_op <= 2'd0; r_cnt <= '0;
        end else if (r_st == BK_DIV) begin
            if (r_cnt == '0) begin
                // load: dividend is magnitude shifted up by the fraction bits
                r_num <= {num_mag, {FRAC{1'b0}}};
                r_den <= den; r_rem <= '0; r_q <= '0;
                r_cnt <= r_cnt + 1'b1;
            end else if (r_cnt < CW'(NW)) begin
                r_cnt <= r_cnt + 1'b1;
                r_num <= {r_num[NW-2:0], 1'b0};
                if (!trial[DW]) begin
                    r_rem <= trial[DW-1:0]; r_q <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[DW-2:0], r_num[NW-1]}; r_q <= {r_q[NW-2:0], 1'b0};
                end
            end else begin
                // last bit, then store the result and move on
                logic [NW-1:0] q;
                q = {r_q[NW-2:0], !trial[DW]};
                r_q <= q;
                r_cnt <= '0;
                r_op <= r_op + 2'd1;
            end
        end
    end

    // the store sees the completed quotient in the cycle after the last bit
    logic r_done;
    logic [1:0] r_done_op;
    logic r_done_neg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else r_done <= r_st == BK_DIV && r_cnt == CW'(NW);
        r_done_op <= r_op;
        r_done_neg <= neg;
    end

    logic [15:0] dres;
    always_comb begin
        dres = '0;
        if (r_den == '0) dres = '0;
        else if (r_done_op[1]) dres = (r_q > NW'(16'hFFFF)) ? 16'hFFFF : r_q[15:0];
        else if (r_done_neg) dres = (r_q > NW'(32768)) ? 16'h8000 : 16'(-r_q[15:0]);
        else dres = (r_q > NW'(32767)) ? 16'h7FFF : r_q[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_done) begin
            case (r_done_op)
                2'd0: r_aj_t <= dres;
                2'd1: r_aj_r <= dres;
                2'd2: r_xj_t <= dres;
                default: r_xj_r <= dres;
            endcase
        end
    end

    // hold the output until the last store has landed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_ok <= 1'b0;
        else r_out_ok <= r_st == BK_OUT;
    end

    assign o_aj_truth = r_aj_t;
    assign o_aj_reco = r_aj_r;
    assign o_xj_truth = r_xj_t;
    assign o_xj_reco = r_xj_r;
    assign o_pair_selected = r_sel;
    assign o_truth_class = r_cls.truth_class;
    assign o_reco_class = r_cls.reco_class;
    assign o_reco_negative = r_sel && r_aj_r[15];
endmodule
`default_nettype wire
